[rtl/usbpd_snk_pkg.sv]
// Shared types and constants for the USB PD sink policy timer unit.
// Holds request kinds, supply and VBUS sense codes, register indexes and reset values.
// Depends on nothing; imported by usb_pd_sink_policy_timer_unit.
package usbpd_snk_pkg;

	// Request kinds carried in req_type.
	localparam logic [2:0] REQ_TICK       = 3'd0;
	localparam logic [2:0] REQ_DETACH     = 3'd1;
	localparam logic [2:0] REQ_ATTACH     = 3'd2;
	localparam logic [2:0] REQ_PROTO_EVT  = 3'd3;
	localparam logic [2:0] REQ_PPS_CHANGE = 3'd4;
	localparam logic [2:0] REQ_OPT_CHANGE = 3'd5;

	// Supply status codes.
	localparam logic [1:0] SUPPLY_NA    = 2'd0;
	localparam logic [1:0] SUPPLY_FIXED = 2'd1;
	localparam logic [1:0] SUPPLY_PPS   = 2'd2;

	// VBUS sense commands.
	localparam logic [1:0] VBUS_KEEP    = 2'd0;
	localparam logic [1:0] VBUS_DISABLE = 2'd1;
	localparam logic [1:0] VBUS_ENABLE  = 2'd2;

	// Configuration register indexes.
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CAPS_WAIT_TIMEOUT  = 3'd0;
	localparam cfg_idx_t CFG_READY_TIMEOUT      = 3'd1;
	localparam cfg_idx_t CFG_KEEPALIVE_INTERVAL = 3'd2;
	localparam cfg_idx_t CFG_POLL_INTERVAL      = 3'd3;
	localparam cfg_idx_t CFG_TWO_STAGE_STARTUP  = 3'd4;

	// Register reset values.
	localparam logic [15:0] CAPS_WAIT_TIMEOUT_RST  = 16'd350;
	localparam logic [15:0] READY_TIMEOUT_RST      = 16'd580;
	localparam logic [13:0] KEEPALIVE_INTERVAL_RST = 14'd5000;
	localparam logic [15:0] POLL_INTERVAL_RST      = 16'd100;

	// Get_Source_Cap attempts before a hard reset.
	localparam logic [1:0] MAX_CAPS_RETRIES = 2'd3;

	// One result of the sequencer.
	typedef struct packed {
		logic       send_get_caps;
		logic       send_hard_reset;
		logic       reset_protocol;
		logic       send_pwr_request;
		logic       apply_second_stage;
		logic [1:0] vbus_sense;
		logic [1:0] power_status;
		logic       default_power_set;
		logic       request_rejected;
		logic       update_taken;
		logic       poll_due;
	} result_t;

	// A timer has run out when the wrapped distance from its mark exceeds the interval.
	function automatic logic elapsed(input logic [15:0] now, input logic [15:0] mark,
			input logic [15:0] interval);
		logic [15:0] diff;
		diff = now - mark;
		return diff > interval;
	endfunction

endpackage

[rtl/usb_pd_sink_policy_timer_unit.sv]
// Top level of the USB PD sink policy timer unit: input register, sequencer logic, result register.
// Depends on usbpd_snk_pkg for request kinds, status codes and the result type.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one request per item: a timer tick, a
//   detach, an attach with both CC levels, protocol events, or an accepted PPS or option
//   update. Every request yields exactly one result on the output channel
//   (out_valid / out_stall), which holds the commands for the host and the supply status.
//   A request is registered in the input register at acceptance and its result in the result
//   register, which drives out_valid; the request moves on only when the result register is free.
//   One request per cycle is sustained while the receiver does not stall; the single stage of
//   sequencer logic between the two registers sets that rate.
//   When the receiver stalls, the result holds in the output register and the request
//   behind it waits in the input register; in_stall rises only when both are occupied.
//   The user must write registers through cfg_wr_en / cfg_index / cfg_wr_data only while idle;
//   the block does not enforce it. A two-stage startup register write rearms the second PPS stage.
//   Reset empties both registers, loads the register defaults and clears all sequencer state.
module usb_pd_sink_policy_timer_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration write port
	input  logic                    cfg_wr_en,
	input  usbpd_snk_pkg::cfg_idx_t cfg_index,
	input  logic [15:0]             cfg_wr_data,
	// Request channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              req_type,
	input  logic [15:0]             now_ms,
	input  logic [1:0]              cc_one_level,
	input  logic [1:0]              cc_two_level,
	input  logic                    got_source_caps,
	input  logic                    got_reject,
	input  logic                    got_ps_ready,
	input  logic                    ready_is_pps,
	input  logic                    update_accepted,
	// Result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    send_get_caps,
	output logic                    send_hard_reset,
	output logic                    reset_protocol,
	output logic                    send_pwr_request,
	output logic                    apply_second_stage,
	output logic [1:0]              vbus_sense,
	output logic [1:0]              power_status,
	output logic                    default_power_set,
	output logic                    request_rejected,
	output logic                    update_taken,
	output logic                    poll_due
);
	import usbpd_snk_pkg::*;

	// Configuration registers
	logic [15:0] caps_wait_timeout_q;
	logic [15:0] ready_timeout_q;
	logic [13:0] keepalive_interval_q;
	logic [15:0] poll_interval_q;
	logic        two_stage_startup_q;

	// Sequencer state
	logic        waiting_caps_q,      waiting_caps_d;
	logic [1:0]  caps_retries_q,      caps_retries_d;
	logic        waiting_ready_q,     waiting_ready_d;
	logic        request_pending_q,   request_pending_d;
	logic [1:0]  supply_status_q,     supply_status_d;
	logic        second_stage_done_q, second_stage_done_d;
	logic [15:0] caps_time_mark_q,    caps_time_mark_d;
	logic [15:0] ready_time_mark_q,   ready_time_mark_d;
	logic [15:0] keepalive_mark_q,    keepalive_mark_d;
	logic [15:0] poll_time_mark_q,    poll_time_mark_d;

	// Input register
	logic        valid_s1;
	logic [2:0]  req_type_s1;
	logic [15:0] now_ms_s1;
	logic [1:0]  cc_one_s1;
	logic [1:0]  cc_two_s1;
	logic        got_caps_s1;
	logic        got_reject_s1;
	logic        got_ps_ready_s1;
	logic        ready_is_pps_s1;
	logic        update_accepted_s1;

	// Result register
	logic        out_valid_q;
	result_t     result_q;
	result_t     result_d;

	logic        advance;
	logic        in_accept;
	logic [1:0]  cc_level;

	// The request in the input register moves on whenever the result register is free.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// Input register load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_type_s1        <= req_type;
			now_ms_s1          <= now_ms;
			cc_one_s1          <= cc_one_level;
			cc_two_s1          <= cc_two_level;
			got_caps_s1        <= got_source_caps;
			got_reject_s1      <= got_reject;
			got_ps_ready_s1    <= got_ps_ready;
			ready_is_pps_s1    <= ready_is_pps;
			update_accepted_s1 <= update_accepted;
		end
	end

	// Attach orientation: a level counts only when exactly one CC line is driven.
	always_comb begin
		if (cc_one_s1 != 2'd0 && cc_two_s1 == 2'd0) begin
			cc_level = cc_one_s1;
		end else if (cc_two_s1 != 2'd0 && cc_one_s1 == 2'd0) begin
			cc_level = cc_two_s1;
		end else begin
			cc_level = 2'd0;
		end
	end

	// Sequencer: next state and result for the request in the input register.
	always_comb begin
		waiting_caps_d      = waiting_caps_q;
		caps_retries_d      = caps_retries_q;
		waiting_ready_d     = waiting_ready_q;
		request_pending_d   = request_pending_q;
		supply_status_d     = supply_status_q;
		second_stage_done_d = second_stage_done_q;
		caps_time_mark_d    = caps_time_mark_q;
		ready_time_mark_d   = ready_time_mark_q;
		keepalive_mark_d    = keepalive_mark_q;
		poll_time_mark_d    = poll_time_mark_q;
		result_d            = '0;

		case (req_type_s1)
			REQ_TICK: begin
				// Source capability retry, then hard reset once retries run out.
				if (waiting_caps_q &&
						elapsed(now_ms_s1, caps_time_mark_q, caps_wait_timeout_q)) begin
					caps_time_mark_d = now_ms_s1;
					if (caps_retries_q < MAX_CAPS_RETRIES) begin
						caps_retries_d         = caps_retries_q + 2'd1;
						result_d.send_get_caps = 1'b1;
					end else begin
						caps_retries_d           = 2'd0;
						result_d.send_hard_reset = 1'b1;
						result_d.reset_protocol  = 1'b1;
					end
				end
				// PS_RDY timeout, or launch of a pending or keep-alive request.
				if (waiting_ready_q) begin
					if (elapsed(now_ms_s1, ready_time_mark_q, ready_timeout_q)) begin
						waiting_ready_d            = 1'b0;
						supply_status_d            = SUPPLY_FIXED;
						result_d.default_power_set = 1'b1;
					end
				end else if (request_pending_q ||
						(supply_status_q == SUPPLY_PPS &&
						elapsed(now_ms_s1, keepalive_mark_q, {2'b00, keepalive_interval_q}))) begin
					waiting_ready_d           = 1'b1;
					request_pending_d         = 1'b0;
					keepalive_mark_d          = now_ms_s1;
					ready_time_mark_d         = now_ms_s1;
					result_d.send_pwr_request = 1'b1;
				end
				// Poll indication.
				if (elapsed(now_ms_s1, poll_time_mark_q, poll_interval_q)) begin
					poll_time_mark_d  = now_ms_s1;
					result_d.poll_due = 1'b1;
				end
			end
			REQ_DETACH: begin
				result_d.reset_protocol = 1'b1;
			end
			REQ_ATTACH: begin
				result_d.reset_protocol = 1'b1;
				if (cc_level > 2'd1) begin
					waiting_caps_d = 1'b1;
				end else begin
					supply_status_d            = SUPPLY_FIXED;
					result_d.default_power_set = 1'b1;
				end
			end
			REQ_PROTO_EVT: begin
				if (got_caps_s1) begin
					waiting_caps_d    = 1'b0;
					caps_retries_d    = 2'd0;
					waiting_ready_d   = 1'b1;
					ready_time_mark_d = now_ms_s1;
				end
				if (got_reject_s1 && waiting_ready_d) begin
					waiting_ready_d           = 1'b0;
					result_d.request_rejected = 1'b1;
				end
				if (got_ps_ready_s1) begin
					waiting_ready_d = 1'b0;
					if (ready_is_pps_s1) begin
						result_d.vbus_sense = VBUS_DISABLE;
						if (two_stage_startup_q && !second_stage_done_q) begin
							second_stage_done_d         = 1'b1;
							request_pending_d           = 1'b1;
							result_d.apply_second_stage = 1'b1;
						end else begin
							keepalive_mark_d = now_ms_s1;
							supply_status_d  = SUPPLY_PPS;
						end
					end else begin
						result_d.vbus_sense = VBUS_ENABLE;
						supply_status_d     = SUPPLY_FIXED;
					end
				end
			end
			REQ_PPS_CHANGE: begin
				if (supply_status_q == SUPPLY_PPS && update_accepted_s1) begin
					request_pending_d     = 1'b1;
					result_d.update_taken = 1'b1;
				end
			end
			REQ_OPT_CHANGE: begin
				if (update_accepted_s1) begin
					request_pending_d     = 1'b1;
					result_d.update_taken = 1'b1;
				end
			end
			default: begin
			end
		endcase

		result_d.power_status = supply_status_d;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_wait_timeout_q  <= CAPS_WAIT_TIMEOUT_RST;
			ready_timeout_q      <= READY_TIMEOUT_RST;
			keepalive_interval_q <= KEEPALIVE_INTERVAL_RST;
			poll_interval_q      <= POLL_INTERVAL_RST;
			two_stage_startup_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CAPS_WAIT_TIMEOUT:  caps_wait_timeout_q  <= cfg_wr_data;
				CFG_READY_TIMEOUT:      ready_timeout_q      <= cfg_wr_data;
				CFG_KEEPALIVE_INTERVAL: keepalive_interval_q <= cfg_wr_data[13:0];
				CFG_POLL_INTERVAL:      poll_interval_q      <= cfg_wr_data;
				CFG_TWO_STAGE_STARTUP:  two_stage_startup_q  <= cfg_wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer state update; a write of the two-stage register rearms the second stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_caps_q      <= 1'b0;
			caps_retries_q      <= 2'd0;
			waiting_ready_q     <= 1'b0;
			request_pending_q   <= 1'b0;
			supply_status_q     <= SUPPLY_NA;
			second_stage_done_q <= 1'b0;
			caps_time_mark_q    <= 16'd0;
			ready_time_mark_q   <= 16'd0;
			keepalive_mark_q    <= 16'd0;
			poll_time_mark_q    <= 16'd0;
		end else begin
			if (advance) begin
				waiting_caps_q    <= waiting_caps_d;
				caps_retries_q    <= caps_retries_d;
				waiting_ready_q   <= waiting_ready_d;
				request_pending_q <= request_pending_d;
				supply_status_q   <= supply_status_d;
				caps_time_mark_q  <= caps_time_mark_d;
				ready_time_mark_q <= ready_time_mark_d;
				keepalive_mark_q  <= keepalive_mark_d;
				poll_time_mark_q  <= poll_time_mark_d;
			end
			if (cfg_wr_en && cfg_index == CFG_TWO_STAGE_STARTUP) begin
				second_stage_done_q <= 1'b0;
			end else if (advance) begin
				second_stage_done_q <= second_stage_done_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid          = out_valid_q;
	assign send_get_caps      = result_q.send_get_caps;
	assign send_hard_reset    = result_q.send_hard_reset;
	assign reset_protocol     = result_q.reset_protocol;
	assign send_pwr_request   = result_q.send_pwr_request;
	assign apply_second_stage = result_q.apply_second_stage;
	assign vbus_sense         = result_q.vbus_sense;
	assign power_status       = result_q.power_status;
	assign default_power_set  = result_q.default_power_set;
	assign request_rejected   = result_q.request_rejected;
	assign update_taken       = result_q.update_taken;
	assign poll_due           = result_q.poll_due;

	// A hard reset always goes out together with a protocol reset.
	a_hard_reset_resets_protocol: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.send_hard_reset |-> result_q.reset_protocol
	) else $error("hard reset issued without protocol reset");

	// A retry and a hard reset never come from the same tick.
	a_caps_retry_exclusive: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({result_q.send_get_caps, result_q.send_hard_reset})
	) else $error("Get_Source_Cap and hard reset in one result");

	// A new request and a fallback to default power exclude each other.
	a_request_or_default: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.send_pwr_request && result_q.default_power_set)
	) else $error("request launched while falling back to default power");

	// A full input register behind a stalled result must hold off the sender.
	a_stall_when_full: assert property (
		@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |-> in_stall
	) else $error("input not stalled while both registers are occupied");

	// The status reported in a fresh result is the state the sequencer keeps.
	a_status_matches_state: assert property (
		@(posedge clk) disable iff (!arst_n)
		advance |=> result_q.power_status == supply_status_q
	) else $error("reported power status differs from sequencer state");

endmodule
